[src/depq_pkg.sv]
package depq_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_BITS = 24;
  localparam int CLIENT_W = 24;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ENT_W    = KEY_BITS + CLIENT_W;

  // operation codes
  localparam logic [1:0] KIND_INS    = 2'd0;
  localparam logic [1:0] KIND_POP_HI = 2'd1;
  localparam logic [1:0] KIND_POP_LO = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef enum logic [2:0] {
    RD_MID,
    RD_LO,
    RD_PREV,
    RD_TOP,
    RD_HEAD
  } rd_src_t;

  typedef struct packed {
    logic       load;
    logic       rd;
    rd_src_t    rd_src;
    logic       step;
    logic       shf_init;
    logic       shf_wr;
    logic       ins;
    logic       pop_hi;
    logic       pop_lo;
    logic       res;
    logic [1:0] res_status;
    logic       res_use;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic full;
    logic srch_done;
    logic dup;
    logic shf_done;
  } stat_t;

endpackage

[src/depq_dp.sv]
module depq_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  depq_pkg::cmd_t                cmd,
  input  logic [23:0]                   in_client_id,
  input  logic [23:0]                   in_priority_req,
  output depq_pkg::stat_t               stat,
  output logic [23:0]                   out_served_client,
  output logic [1:0]                    out_status
);
  import depq_pkg::*;

  logic [ENT_W-1:0]    mem [CAPACITY];
  logic [ENT_W-1:0]    rdata_r;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    lo_r, hi_r, idx_r;
  logic [KEY_BITS-1:0] key_r;
  logic [CLIENT_W-1:0] client_r;
  logic [CLIENT_W-1:0] out_client_r;
  logic [1:0]          out_status_r;
  logic [CNT_W-1:0]    mid;
  logic [IDX_W-1:0]    rd_addr, wr_addr;
  logic                wr_en;
  logic [ENT_W-1:0]    wr_data;
  logic [KEY_BITS-1:0] rd_key;
  logic [CLIENT_W-1:0] rd_client;

  // map a position in sorted order onto the circular store
  function automatic logic [IDX_W-1:0] phys(logic [IDX_W-1:0] h, logic [CNT_W-1:0] x);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(h) + (CNT_W+1)'(x);
    if (s >= (CNT_W+1)'(CAPACITY)) s = s - (CNT_W+1)'(CAPACITY);
    return s[IDX_W-1:0];
  endfunction

  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign rd_key    = rdata_r[ENT_W-1:CLIENT_W];
  assign rd_client = rdata_r[CLIENT_W-1:0];

  // select read address
  always_comb begin
    unique case (cmd.rd_src)
      RD_MID:  rd_addr = phys(head_r, mid);
      RD_LO:   rd_addr = phys(head_r, lo_r);
      RD_PREV: rd_addr = phys(head_r, idx_r - CNT_W'(1));
      RD_TOP:  rd_addr = phys(head_r, count_r - CNT_W'(1));
      default: rd_addr = head_r;
    endcase
  end

  // select write: shift one entry up, or place the new entry
  assign wr_en   = cmd.shf_wr | cmd.ins;
  assign wr_addr = cmd.shf_wr ? phys(head_r, idx_r) : phys(head_r, lo_r);
  assign wr_data = cmd.shf_wr ? rdata_r : {key_r, client_r};

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd) rdata_r <= mem[rd_addr];
  end

  // advance head and fill count
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.ins) count_nxt = count_r + CNT_W'(1);
    if (cmd.pop_hi) count_nxt = count_r - CNT_W'(1);
    if (cmd.pop_lo) begin
      count_nxt = count_r - CNT_W'(1);
      head_nxt  = (head_r == IDX_W'(CAPACITY - 1)) ? '0 : head_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // request latch, binary search bounds and shift index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r    <= in_priority_req[KEY_BITS-1:0];
      client_r <= in_client_id;
      lo_r     <= '0;
      hi_r     <= count_r;
    end
    if (cmd.step) begin
      if (rd_key < key_r) lo_r <= mid + CNT_W'(1);
      else hi_r <= mid;
    end
    if (cmd.shf_init) idx_r <= count_r;
    if (cmd.shf_wr) idx_r <= idx_r - CNT_W'(1);
    if (cmd.res) begin
      out_client_r <= cmd.res_use ? rd_client : '0;
      out_status_r <= cmd.res_status;
    end
  end

  assign stat.cnt_zero  = (count_r == '0);
  assign stat.full      = (count_r == CNT_W'(CAPACITY));
  assign stat.srch_done = (lo_r == hi_r);
  assign stat.dup       = (lo_r < count_r) && (rd_key == key_r);
  assign stat.shf_done  = (idx_r == lo_r);

  assign out_served_client = out_client_r;
  assign out_status        = out_status_r;

endmodule

[src/depq_ctrl.sv]
module depq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_kind,
  output logic            out_valid,
  input  logic            out_ready,
  input  depq_pkg::stat_t stat,
  output depq_pkg::cmd_t  cmd
);
  import depq_pkg::*;

  typedef enum logic [10:0] {
    IDLE  = 11'b000_0000_0001,
    S_RD  = 11'b000_0000_0010,
    S_CMP = 11'b000_0000_0100,
    C_RD  = 11'b000_0000_1000,
    C_CMP = 11'b000_0001_0000,
    H_RD  = 11'b000_0010_0000,
    H_WR  = 11'b000_0100_0000,
    INS   = 11'b000_1000_0000,
    PH    = 11'b001_0000_0000,
    PL    = 11'b010_0000_0000,
    FIN   = 11'b100_0000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] st_r, st_nxt;
  logic       use_r, use_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // sequence one request at a time
  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    use_nxt   = use_r;
    cmd       = '0;
    cmd.rd_src = RD_HEAD;
    unique case (state_r)
      IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          use_nxt  = 1'b0;
          st_nxt   = ST_OK;
          priority case (in_kind)
            KIND_INS:    state_nxt = S_RD;
            KIND_POP_HI: begin
              if (stat.cnt_zero) begin
                st_nxt = ST_EMPTY;
                state_nxt = FIN;
              end else state_nxt = PH;
            end
            KIND_POP_LO: begin
              if (stat.cnt_zero) begin
                st_nxt = ST_EMPTY;
                state_nxt = FIN;
              end else state_nxt = PL;
            end
            default:     state_nxt = FIN;
          endcase
        end
      end
      S_RD: begin
        if (stat.srch_done) state_nxt = C_RD;
        else begin
          cmd.rd     = 1'b1;
          cmd.rd_src = RD_MID;
          state_nxt  = S_CMP;
        end
      end
      S_CMP: begin
        cmd.step  = 1'b1;
        state_nxt = S_RD;
      end
      C_RD: begin
        cmd.rd     = 1'b1;
        cmd.rd_src = RD_LO;
        state_nxt  = C_CMP;
      end
      C_CMP: begin
        cmd.shf_init = 1'b1;
        if (stat.dup) begin
          st_nxt    = ST_DUP;
          state_nxt = FIN;
        end else if (stat.full) begin
          st_nxt    = ST_FULL;
          state_nxt = FIN;
        end else state_nxt = H_RD;
      end
      H_RD: begin
        if (stat.shf_done) state_nxt = INS;
        else begin
          cmd.rd     = 1'b1;
          cmd.rd_src = RD_PREV;
          state_nxt  = H_WR;
        end
      end
      H_WR: begin
        cmd.shf_wr = 1'b1;
        state_nxt  = H_RD;
      end
      INS: begin
        cmd.ins   = 1'b1;
        state_nxt = FIN;
      end
      PH: begin
        cmd.rd     = 1'b1;
        cmd.rd_src = RD_TOP;
        cmd.pop_hi = 1'b1;
        use_nxt    = 1'b1;
        state_nxt  = FIN;
      end
      PL: begin
        cmd.rd     = 1'b1;
        cmd.rd_src = RD_HEAD;
        cmd.pop_lo = 1'b1;
        use_nxt    = 1'b1;
        state_nxt  = FIN;
      end
      FIN: begin
        if (out_free) begin
          cmd.res        = 1'b1;
          cmd.res_status = st_r;
          cmd.res_use    = use_r;
          state_nxt      = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  // hold result valid until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
      st_r        <= ST_OK;
      use_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
      use_r       <= use_nxt;
    end
  end

endmodule

[src/double_ended_priority_queue.sv]
// Double-ended priority queue of client identifiers keyed by unique priorities.
// Input channel (in_valid/in_ready): in_kind selects insert, pop highest or
// pop lowest; in_client_id and in_priority_req are used by inserts only.
// Result channel (out_valid/out_ready): one result per request, carrying the
// served client (zero unless a pop succeeds) and a status: ok, duplicate
// priority, queue empty or queue full.
// Entries sit in sorted order in a single-port-read circular store; the
// lowest entry is at the head pointer, so neither pop moves any entries.
// An insert binary-searches the store (up to ceil(log2(count+1)) probes),
// checks the slot found, then moves every larger entry up by one and
// writes. The store gives one memory read per cycle, so the probes and
// moves run one after another, and a new request is accepted only once
// the result of the previous one has been issued.
// Reset empties the queue at once; no clearing pass is needed.
// A new request is taken while a finished result waits; if the receiver
// stalls, the next result is held internally until the output register frees.
module double_ended_priority_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [23:0] in_client_id,
  input  logic [23:0] in_priority_req,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_served_client,
  output logic [1:0]  out_status
);
  import depq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  depq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  depq_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_client_id      (in_client_id),
    .in_priority_req   (in_priority_req),
    .stat              (stat),
    .out_served_client (out_served_client),
    .out_status        (out_status)
  );

endmodule

[src/depq_checker.sv]
module depq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_served_client,
  input logic [1:0]  out_status
);
  import depq_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_served_client)
      && $stable(out_status))
    else $error("stalled result changed");

  // empty pop serves no client
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_served_client == '0)
    else $error("empty pop returned a client");

  // rejected inserts serve no client
  a_rej: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_DUP || out_status == ST_FULL)
      |-> out_served_client == '0)
    else $error("rejected insert returned a client");

  // no result straight after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an accepted request cannot yield a result in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result too early");

endmodule

bind double_ended_priority_queue depq_checker u_depq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_served_client (out_served_client),
  .out_status        (out_status)
);
